### hw/rtl/spt_pkg.sv
// shared types, widths and codes of the section time profiler table
`timescale 1ns / 1ps
package spt_pkg;

   localparam int FUNC_W          = 2;
   localparam int ID_W            = 8;
   localparam int TS_W            = 63;
   localparam int LVL_W           = 9;
   localparam int CNT_W           = 32;
   localparam int ERR_W           = 3;
   localparam int DEF_NUM_ENTRIES = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_UNUSED = 2'd3
   } func_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK            = 3'd0,
      ERR_ALREADY_OPEN  = 3'd1,
      ERR_NOT_OPEN      = 3'd2,
      ERR_LEVEL         = 3'd3,
      ERR_BAD_ID        = 3'd4,
      ERR_OPEN_AT_CLEAR = 3'd5
   } err_type;

   // one table entry as seen by the event logic
   typedef struct packed {
      logic [TS_W-1:0]  start_time;
      logic [TS_W-1:0]  accum_time;
      logic [CNT_W-1:0] repeat_count;
      logic [LVL_W-1:0] owner_level;
      logic             has_run;
      logic             is_open;
   } entry_type;

   // table update control from the event logic
   typedef struct packed {
      logic wr_en;
      logic clr_en;
   } upd_type;

endpackage

### hw/rtl/section_time_profiler_table_core.sv
// top level of the section time profiler table
`timescale 1ns / 1ps
// usage
//   - events enter on the req_ ports: an event beat is taken at a rising edge
//     with start high and busy low; busy is always low, so one event can be
//     taken every cycle
//   - each event gives exactly one result beat on the rsp_ ports, shown for
//     one cycle with rsp_strobe high; the receiver cannot stall it
//   - pipeline: the event is registered at its accept edge, checked and
//     applied to the table in the following cycle, and the result register
//     loads at the next edge, which raises rsp_strobe
//   - throughput: one event per cycle; the table update and result register
//     load share one edge, so an event right behind another on the same entry
//     sees the updated entry
//   - the critical path is the 63-bit duration subtract feeding the
//     saturating 63-bit total add through the entry read mux
//   - reset (synchronous, active high) empties the pipeline, closes every
//     entry and zeroes totals, repeat counts and the clear time; start times
//     and owner levels are written by a push before they are ever read
//   - a clear zeroes totals, repeat counts and flags of every entry in its own cycle, no sweep is needed
module section_time_profiler_table_core
   import spt_pkg::*;
#(
   parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   // event channel
   input  logic              start,
   output logic              busy,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [ID_W-1:0]   req_entry_id,
   input  logic [TS_W-1:0]   req_timestamp,
   input  logic [LVL_W-1:0]  req_level,
   input  logic              req_check_idle,
   // result channel
   output logic              rsp_strobe,
   output logic [ERR_W-1:0]  rsp_error_code,
   output logic [TS_W-1:0]   rsp_total_us,
   output logic [CNT_W-1:0]  rsp_extra_count,
   output logic [TS_W-1:0]   rsp_duration_us,
   output logic [TS_W-1:0]   rsp_since_clear_us
);

   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   // input register
   logic              in_vld_ff;
   logic [FUNC_W-1:0] func_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TS_W-1:0]   ts_ff;
   logic [LVL_W-1:0]  lvl_ff;
   logic              chk_ff;
   logic              accept;

   // table interface
   logic [IDX_W-1:0]  idx;
   upd_type           upd;
   upd_type           upd_gated;
   entry_type         wr_entry;
   entry_type         rd_entry;
   logic [TS_W-1:0]   clear_time;
   logic              any_open;

   // result before the output register
   logic [ERR_W-1:0]  err_in;
   logic [TS_W-1:0]   total_in;
   logic [CNT_W-1:0]  extra_in;
   logic [TS_W-1:0]   dur_in;
   logic [TS_W-1:0]   since_in;

   // output register
   logic              out_vld_ff;
   logic [ERR_W-1:0]  err_ff;
   logic [TS_W-1:0]   total_ff;
   logic [CNT_W-1:0]  extra_ff;
   logic [TS_W-1:0]   dur_ff;
   logic [TS_W-1:0]   since_ff;

   // single-pass datapath: never holds events off
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= accept;
      end
   end

   // payload capture, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         id_ff   <= req_entry_id;
         ts_ff   <= req_timestamp;
         lvl_ff  <= req_level;
         chk_ff  <= req_check_idle;
      end
   end

   spt_event_logic #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_event (
      .func           (func_ff),
      .entry_id       (id_ff),
      .timestamp      (ts_ff),
      .level          (lvl_ff),
      .check_idle     (chk_ff),
      .rd_entry       (rd_entry),
      .clear_time     (clear_time),
      .any_open       (any_open),
      .idx            (idx),
      .upd            (upd),
      .wr_entry       (wr_entry),
      .error_code     (err_in),
      .total_us       (total_in),
      .extra_count    (extra_in),
      .duration_us    (dur_in),
      .since_clear_us (since_in)
   );

   // table only changes for a live event
   always_comb begin
      upd_gated.wr_en  = upd.wr_en && in_vld_ff;
      upd_gated.clr_en = upd.clr_en && in_vld_ff;
   end

   spt_entry_table #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .idx        (idx),
      .upd        (upd_gated),
      .wr_entry   (wr_entry),
      .clr_time   (ts_ff),
      .rd_entry   (rd_entry),
      .clear_time (clear_time),
      .any_open   (any_open)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld_ff) begin
         err_ff   <= err_in;
         total_ff <= total_in;
         extra_ff <= extra_in;
         dur_ff   <= dur_in;
         since_ff <= since_in;
      end
   end

   assign rsp_strobe         = out_vld_ff;
   assign rsp_error_code     = err_ff;
   assign rsp_total_us       = total_ff;
   assign rsp_extra_count    = extra_ff;
   assign rsp_duration_us    = dur_ff;
   assign rsp_since_clear_us = since_ff;

endmodule

### hw/rtl/spt_entry_table.sv
// flop table of profiled sections with single read port and bulk clear
`timescale 1ns / 1ps
module spt_entry_table
   import spt_pkg::*;
#(
   parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
   parameter int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] idx,
   input  upd_type          upd,
   input  entry_type        wr_entry,
   input  logic [TS_W-1:0]  clr_time,
   output entry_type        rd_entry,
   output logic [TS_W-1:0]  clear_time,
   output logic             any_open
);

   logic [TS_W-1:0]  start_ff  [NUM_ENTRIES];
   logic [LVL_W-1:0] level_ff  [NUM_ENTRIES];
   logic [TS_W-1:0]  total_ff  [NUM_ENTRIES];
   logic [CNT_W-1:0] repeat_ff [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] run_ff;
   logic [NUM_ENTRIES-1:0] open_ff;
   logic [TS_W-1:0]  clear_ff;

   // start time and level only matter once written
   always_ff @(posedge clock) begin
      if (upd.wr_en && !upd.clr_en) begin
         start_ff[idx] <= wr_entry.start_time;
         level_ff[idx] <= wr_entry.owner_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || upd.clr_en) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            total_ff[i]  <= '0;
            repeat_ff[i] <= '0;
         end
         run_ff  <= '0;
         open_ff <= '0;
      end else if (upd.wr_en) begin
         total_ff[idx]  <= wr_entry.accum_time;
         repeat_ff[idx] <= wr_entry.repeat_count;
         run_ff[idx]    <= wr_entry.has_run;
         open_ff[idx]   <= wr_entry.is_open;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= '0;
      end else if (upd.clr_en) begin
         clear_ff <= clr_time;
      end
   end

   always_comb begin
      rd_entry.start_time   = start_ff[idx];
      rd_entry.accum_time   = total_ff[idx];
      rd_entry.repeat_count = repeat_ff[idx];
      rd_entry.owner_level  = level_ff[idx];
      rd_entry.has_run      = run_ff[idx];
      rd_entry.is_open      = open_ff[idx];
   end

   assign clear_time = clear_ff;
   assign any_open   = |open_ff;

endmodule

### hw/rtl/spt_event_logic.sv
// per-event checks, entry update and result fields
`timescale 1ns / 1ps
module spt_event_logic
   import spt_pkg::*;
#(
   parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
   parameter int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
   input  logic [FUNC_W-1:0] func,
   input  logic [ID_W-1:0]   entry_id,
   input  logic [TS_W-1:0]   timestamp,
   input  logic [LVL_W-1:0]  level,
   input  logic              check_idle,
   input  entry_type         rd_entry,
   input  logic [TS_W-1:0]   clear_time,
   input  logic              any_open,
   output logic [IDX_W-1:0]  idx,
   output upd_type           upd,
   output entry_type         wr_entry,
   output logic [ERR_W-1:0]  error_code,
   output logic [TS_W-1:0]   total_us,
   output logic [CNT_W-1:0]  extra_count,
   output logic [TS_W-1:0]   duration_us,
   output logic [TS_W-1:0]   since_clear_us
);

   localparam logic [ID_W:0] NUM_LIM = (ID_W+1)'(NUM_ENTRIES);

   logic            id_ok;
   logic [TS_W-1:0] dur;
   logic [TS_W:0]   sum;
   logic [TS_W-1:0] sat_sum;
   err_type         err;
   entry_type       post;

   assign id_ok = {1'b0, entry_id} < NUM_LIM;
   assign idx   = id_ok ? entry_id[IDX_W-1:0] : '0;
   assign dur   = timestamp - rd_entry.start_time;
   assign sum   = {1'b0, rd_entry.accum_time} + {1'b0, dur};
   assign sat_sum = sum[TS_W] ? '1 : sum[TS_W-1:0];

   always_comb begin
      err         = ERR_OK;
      upd         = '0;
      post        = rd_entry;
      duration_us = '0;
      case (func_type'(func))
         FUNC_PUSH: begin
            if (!id_ok) begin
               err = ERR_BAD_ID;
            end else if (rd_entry.is_open) begin
               err = ERR_ALREADY_OPEN;
            end else begin
               upd.wr_en = 1'b1;
               if (rd_entry.has_run && rd_entry.repeat_count != '1) begin
                  post.repeat_count = rd_entry.repeat_count + 1'b1;
               end
               post.owner_level = level;
               post.start_time  = timestamp;
               post.is_open     = 1'b1;
            end
         end
         FUNC_POP: begin
            if (!id_ok) begin
               err = ERR_BAD_ID;
            end else if (!rd_entry.is_open) begin
               err = ERR_NOT_OPEN;
            end else if (rd_entry.owner_level != level) begin
               err = ERR_LEVEL;
            end else begin
               upd.wr_en       = 1'b1;
               duration_us     = dur;
               post.accum_time = sat_sum;
               post.is_open    = 1'b0;
               post.has_run    = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            if (check_idle && any_open) begin
               err = ERR_OPEN_AT_CLEAR;
            end else begin
               upd.clr_en        = 1'b1;
               post.accum_time   = '0;
               post.repeat_count = '0;
               post.has_run      = 1'b0;
               post.is_open      = 1'b0;
            end
         end
         default: begin
            // unused kind: no change, report entry as it stands
         end
      endcase
   end

   assign wr_entry       = post;
   assign error_code     = err;
   assign total_us       = id_ok ? post.accum_time : '0;
   assign extra_count    = id_ok ? post.repeat_count : '0;
   assign since_clear_us = upd.clr_en ? '0 : (timestamp - clear_time);

endmodule

### sim/section_time_profiler_table_core_tb.sv
// self-checking testbench for the section time profiler table core
`timescale 1ns / 1ps
module section_time_profiler_table_core_tb;
   import spt_pkg::*;

   localparam int TABLE_DEPTH  = DEF_NUM_ENTRIES;
   localparam int RANDOM_BEATS = 1450;
   // closing stretch of the random part with no sender gaps
   localparam int QUIET_BEATS  = 200;
   // idle cycles run after every predicted result beat has come back
   localparam int DRAIN_CYCLES = 8;
   // slowest run is about 1500 beats with their sender gaps, well below this
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

   // one expected result beat
   typedef struct {
      err_type          err;
      logic [TS_W-1:0]  total;
      logic [CNT_W-1:0] extra;
      logic [TS_W-1:0]  duration;
      logic [TS_W-1:0]  since_clear;
   } profile_result_type;

   // shadow copy of the section table plus the results it predicts
   class section_table_tracker_type;
      logic [TS_W-1:0]  entry_start   [TABLE_DEPTH];
      logic [TS_W-1:0]  entry_total   [TABLE_DEPTH];
      logic [CNT_W-1:0] entry_repeats [TABLE_DEPTH];
      logic [LVL_W-1:0] entry_level   [TABLE_DEPTH];
      bit               entry_ran     [TABLE_DEPTH];
      bit               entry_open    [TABLE_DEPTH];
      logic [TS_W-1:0]  last_clear;
      profile_result_type pending_results[$];
      int unsigned      mismatches;

      function new();
         foreach (entry_total[i]) begin
            entry_start[i]   = '0;
            entry_total[i]   = '0;
            entry_repeats[i] = '0;
            entry_level[i]   = '0;
            entry_ran[i]     = 1'b0;
            entry_open[i]    = 1'b0;
         end
         last_clear = '0;
         mismatches = 0;
      endfunction

      // apply one accepted event beat to the shadow table and queue its result
      function void note_event(func_type f, logic [ID_W-1:0] id, logic [TS_W-1:0] ts,
                               logic [LVL_W-1:0] lvl, logic chk);
         profile_result_type r;
         bit              known;
         bit              some_open;
         int              k;
         logic [TS_W:0]   sum;
         known = id < TABLE_DEPTH;
         k = known ? int'(id) : 0;
         r.err = ERR_OK;
         r.duration = '0;
         case (f)
            FUNC_PUSH: begin
               if (!known) r.err = ERR_BAD_ID;
               else if (entry_open[k]) r.err = ERR_ALREADY_OPEN;
               else begin
                  // a repeat call only counts once the section has completed before
                  if (entry_ran[k] && entry_repeats[k] != '1) entry_repeats[k]++;
                  entry_level[k] = lvl;
                  entry_start[k] = ts;
                  entry_open[k]  = 1'b1;
               end
            end
            FUNC_POP: begin
               if (!known) r.err = ERR_BAD_ID;
               else if (!entry_open[k]) r.err = ERR_NOT_OPEN;
               else if (entry_level[k] != lvl) r.err = ERR_LEVEL;
               else begin
                  r.duration = ts - entry_start[k];
                  sum = {1'b0, entry_total[k]} + {1'b0, r.duration};
                  entry_total[k] = sum[TS_W] ? TS_MAX : sum[TS_W-1:0];
                  entry_open[k]  = 1'b0;
                  entry_ran[k]   = 1'b1;
               end
            end
            FUNC_CLEAR: begin
               some_open = 1'b0;
               foreach (entry_open[i]) some_open |= entry_open[i];
               if (chk && some_open) r.err = ERR_OPEN_AT_CLEAR;
               else begin
                  last_clear = ts;
                  foreach (entry_total[i]) begin
                     entry_total[i]   = '0;
                     entry_repeats[i] = '0;
                     entry_ran[i]     = 1'b0;
                     entry_open[i]    = 1'b0;
                  end
               end
            end
            default: ;
         endcase
         r.total       = known ? entry_total[k] : '0;
         r.extra       = known ? entry_repeats[k] : '0;
         r.since_clear = ts - last_clear;
         pending_results.push_back(r);
      endfunction

      // random currently open entry, or -1 when none is open
      function int pick_open();
         int open_ids[$];
         foreach (entry_open[i]) if (entry_open[i]) open_ids.push_back(i);
         if (open_ids.size() == 0) return -1;
         return open_ids[$urandom_range(0, open_ids.size() - 1)];
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
         end
      endfunction

      // compare one result beat with the oldest prediction
      function void check_result(logic [ERR_W-1:0] err, logic [TS_W-1:0] total,
                                 logic [CNT_W-1:0] extra, logic [TS_W-1:0] duration,
                                 logic [TS_W-1:0] since_clear);
         profile_result_type want;
         if (pending_results.size() == 0) begin
            $error("result beat with no event waiting: error_code %0d", err);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("error_code", want.err, err);
         compare_field("total_us", want.total, total);
         compare_field("extra_count", want.extra, extra);
         compare_field("duration_us", want.duration, duration);
         compare_field("since_clear_us", want.since_clear, since_clear);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [FUNC_W-1:0] req_func;
   logic [ID_W-1:0]   req_entry_id;
   logic [TS_W-1:0]   req_timestamp;
   logic [LVL_W-1:0]  req_level;
   logic              req_check_idle;
   logic              rsp_strobe;
   logic [ERR_W-1:0]  rsp_error_code;
   logic [TS_W-1:0]   rsp_total_us;
   logic [CNT_W-1:0]  rsp_extra_count;
   logic [TS_W-1:0]   rsp_duration_us;
   logic [TS_W-1:0]   rsp_since_clear_us;

   section_table_tracker_type tracker;
   logic [TS_W-1:0]      now_us;
   int unsigned          cycle_count = 0;

   section_time_profiler_table_core #(
      .NUM_ENTRIES(TABLE_DEPTH)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_entry_id       (req_entry_id),
      .req_timestamp      (req_timestamp),
      .req_level          (req_level),
      .req_check_idle     (req_check_idle),
      .rsp_strobe         (rsp_strobe),
      .rsp_error_code     (rsp_error_code),
      .rsp_total_us       (rsp_total_us),
      .rsp_extra_count    (rsp_extra_count),
      .rsp_duration_us    (rsp_duration_us),
      .rsp_since_clear_us (rsp_since_clear_us)
   );

   // 4 ns clock
   always #2 clock = ~clock;

   // run guard: a hung handshake or a lost result ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: the receiver cannot stall, so every strobed beat is taken
   // at the edge that ends its cycle; outputs are read before that edge updates them
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.check_result(rsp_error_code, rsp_total_us, rsp_extra_count,
                              rsp_duration_us, rsp_since_clear_us);
   end

   function automatic logic [TS_W-1:0] rand_stamp();
      return TS_W'({$urandom, $urandom});
   endfunction

   // present one event beat and hold it until the block takes it
   task automatic send_event(func_type f, logic [ID_W-1:0] id, logic [TS_W-1:0] ts,
                             logic [LVL_W-1:0] lvl, logic chk);
      start          <= 1'b1;
      req_func       <= f;
      req_entry_id   <= id;
      req_timestamp  <= ts;
      req_level      <= lvl;
      req_check_idle <= chk;
      do @(posedge clock); while (busy);
      tracker.note_event(f, id, ts, lvl, chk);
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold the sender off until every predicted result beat has come back
   task automatic wait_results_drained();
      start <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
   endtask

   // one random event: mostly well-formed push/pop pairs on a few busy entries,
   // the rest clears, out-of-range ids and raw noise
   task automatic random_event();
      int               pick;
      int               open_id;
      logic [LVL_W-1:0] lvl;
      pick = $urandom_range(0, 99);
      // time mostly runs forward, now and then it jumps anywhere (wrap cases)
      if ($urandom_range(0, 32) == 0) now_us = rand_stamp();
      else now_us = now_us + TS_W'($urandom_range(0, 2000));
      if (pick < 40) begin
         lvl = ($urandom_range(0, 3) == 0) ? LVL_W'($urandom) : LVL_W'($urandom_range(0, 3));
         send_event(FUNC_PUSH,
                    ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, TABLE_DEPTH - 1))
                                                : ID_W'($urandom_range(0, 7)),
                    now_us, lvl, 1'($urandom));
      end else if (pick < 78) begin
         open_id = tracker.pick_open();
         if (open_id < 0) begin
            send_event(FUNC_POP, ID_W'($urandom_range(0, 7)), now_us,
                       LVL_W'($urandom_range(0, 3)), 1'($urandom));
         end else begin
            // occasionally pop from the wrong level
            lvl = ($urandom_range(0, 9) == 0) ? LVL_W'($urandom)
                                              : tracker.entry_level[open_id];
            send_event(FUNC_POP, ID_W'(open_id), now_us, lvl, 1'($urandom));
         end
      end else if (pick < 84) begin
         send_event(FUNC_CLEAR, ID_W'($urandom), now_us, LVL_W'($urandom), 1'($urandom));
      end else if (pick < 92) begin
         send_event($urandom_range(0, 1) ? FUNC_POP : FUNC_PUSH,
                    ID_W'($urandom_range(TABLE_DEPTH, 255)), now_us,
                    LVL_W'($urandom), 1'($urandom));
      end else begin
         send_event(func_type'($urandom_range(0, 3)), ID_W'($urandom), now_us,
                    LVL_W'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      tracker        = new();
      reset          <= 1'b1;
      start          <= 1'b0;
      req_func       <= FUNC_PUSH;
      req_entry_id   <= '0;
      req_timestamp  <= '0;
      req_level      <= '0;
      req_check_idle <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed beats, issued back to back
      send_event(FUNC_CLEAR, 8'd0, 63'd1000, 9'd0, 1'b0);
      // plain push/pop, then a repeat call on the same entry
      send_event(FUNC_PUSH, 8'd0, 63'd1100, 9'd0, 1'b0);
      send_event(FUNC_POP, 8'd0, 63'd1350, 9'd0, 1'b0);
      send_event(FUNC_PUSH, 8'd0, 63'd1400, 9'd7, 1'b0);
      // push on an already open entry, pop from the wrong level
      send_event(FUNC_PUSH, 8'd0, 63'd1410, 9'd7, 1'b0);
      send_event(FUNC_POP, 8'd0, 63'd1420, 9'd8, 1'b0);
      send_event(FUNC_POP, 8'd0, 63'd1500, 9'd7, 1'b0);
      // pop of an entry that is not open
      send_event(FUNC_POP, 8'd1, 63'd1510, 9'd0, 1'b0);
      // ids past the end of the table
      send_event(FUNC_PUSH, 8'd255, 63'd1520, 9'd0, 1'b1);
      send_event(FUNC_POP, ID_W'(TABLE_DEPTH), 63'd1530, 9'd0, 1'b0);
      // last entry, top level, clock wrap from the largest stamp to zero
      send_event(FUNC_PUSH, ID_W'(TABLE_DEPTH - 1), TS_MAX, 9'h1FF, 1'b0);
      send_event(FUNC_POP, ID_W'(TABLE_DEPTH - 1), 63'd0, 9'h1FF, 1'b0);
      // two wrapped durations drive the total into saturation
      send_event(FUNC_PUSH, 8'd5, 63'd1, 9'd2, 1'b0);
      send_event(FUNC_POP, 8'd5, 63'd0, 9'd2, 1'b0);
      send_event(FUNC_PUSH, 8'd5, 63'd10, 9'd2, 1'b0);
      send_event(FUNC_POP, 8'd5, 63'd5, 9'd2, 1'b0);
      // idle-checked clear with an entry open is refused
      send_event(FUNC_PUSH, 8'd3, 63'd2000, 9'd100, 1'b0);
      send_event(FUNC_CLEAR, 8'd3, 63'd2010, 9'd0, 1'b1);
      // unused kind only reports the entry
      send_event(FUNC_UNUSED, 8'd3, 63'd2020, 9'd0, 1'b1);
      send_event(FUNC_UNUSED, 8'd200, 63'd2030, 9'd0, 1'b0);
      send_event(FUNC_POP, 8'd3, 63'd2100, 9'd100, 1'b0);
      send_event(FUNC_CLEAR, 8'd3, 63'd2200, 9'd0, 1'b1);
      // unchecked clear closes an open entry
      send_event(FUNC_PUSH, 8'd9, 63'd2300, 9'd1, 1'b0);
      send_event(FUNC_CLEAR, 8'd9, 63'd2400, 9'd0, 1'b0);
      send_event(FUNC_POP, 8'd9, 63'd2500, 9'd1, 1'b0);

      wait_results_drained();
      now_us = 63'd3000;

      // random part, with sender gaps except in the closing stretch
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         random_event();
         if (n < RANDOM_BEATS - QUIET_BEATS && $urandom_range(0, 6) == 0)
            pause_sender($urandom_range(1, 12));
      end

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
